>>> rtl/core/top_n_score_ranker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-N score ranker
// Wraps concurrent assertions with a clock and an optional reset qualifier.
// ----------------------------------------------------------------------------
`ifndef TOP_N_SCORE_RANKER_ASSERT_SVH
`define TOP_N_SCORE_RANKER_ASSERT_SVH

// Assertion that is switched off while reset is held
`define TNSR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked through reset
`define TNSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tnsr_pkg.sv
// ----------------------------------------------------------------------------
// tnsr_pkg
// Shared widths, payload types and sequencer states of the top-N score ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package tnsr_pkg;

    localparam int TNSR_MAX_ENTRIES = 32;
    localparam int TOP_N_W          = 6;
    localparam int ID_W             = 16;
    localparam int SCORE_W          = 32;
    localparam int RANK_W           = 5;
    localparam int RESULT_LIMIT     = 32;
    localparam logic [TOP_N_W-1:0] TOP_N_RESET = TOP_N_W'(1);

    // candidate broadcast to every cell
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } tnsr_cand_t;

    // stored entry as seen by the output sequencer
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } tnsr_entry_t;

    // what one cell hands to its right-hand neighbour
    typedef struct packed {
        logic                      valid;    // occupied, after a query clear
        logic                      greater;  // outranks the current candidate
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } tnsr_link_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } tnsr_state_t;

endpackage

`default_nettype wire

>>> rtl/core/top_n_score_ranker.sv
// A candidate is compared and written into the list registers when accepted.
// Throughput: one candidate per cycle while no list streams out; after an
//   item with last_item set the list streams out at one entry per cycle while
//   m_ready is high, the first entry valid once the emit state has loaded it
//   into the output stage, s_ready low from acceptance until the final one loads.
// Reset (aresetn low, synchronous): list empty, top_n back to 1, outputs idle.
// ----------------------------------------------------------------------------
// top_n_score_ranker
// Keeps the best-scoring candidates of a query, sorted highest first, in a
// chain of compare-and-shift cells, and streams the list out on request.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_score_ranker
    import tnsr_pkg::*;
#(
    parameter int MAX_ENTRIES = TNSR_MAX_ENTRIES
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration: top_n
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [TOP_N_W-1:0]        cfg_data,
    // candidate items
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_first_item,
    input  wire logic                      s_last_item,
    input  wire logic [ID_W-1:0]           s_cand_id,
    input  wire logic signed [SCORE_W-1:0] s_cand_score,
    // ranked result items
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [RANK_W-1:0]              m_rank,
    output logic [ID_W-1:0]                m_ranked_id,
    output logic signed [SCORE_W-1:0]      m_ranked_score,
    output logic                           m_final_entry
);

    // count width holds 0..MAX_ENTRIES; limit arithmetic needs room for top_n too
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > TOP_N_W) ? CW : TOP_N_W;
    localparam int EW = (CW > RANK_W + 1) ? CW : RANK_W + 1;

    logic [TOP_N_W-1:0] top_n_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      top_n_ext;
    logic [CW-1:0]      lim;
    logic [CW-1:0]      count_base;
    logic [CW-1:0]      count_ins;
    logic [CW-1:0]      count_after;
    logic [EW-1:0]      count_wide;
    logic [RANK_W-1:0]  last_idx;
    logic               accept;
    logic               drop;
    logic               busy;
    tnsr_cand_t         cand;
    tnsr_link_t         link [MAX_ENTRIES+1];
    tnsr_entry_t        entries [MAX_ENTRIES];

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign cand      = '{id: s_cand_id, score: s_cand_score};

    // Clamp top_n into 1..MAX_ENTRIES
    assign top_n_ext = LW'(top_n_reg);
    always_comb begin
        priority if (top_n_ext == '0) begin
            lim = CW'(1);
        end else if (top_n_ext > LW'(MAX_ENTRIES)) begin
            lim = CW'(MAX_ENTRIES);
        end else begin
            lim = CW'(top_n_ext);
        end
    end

    // Head of the chain: nothing outranks a candidate there, slot always fillable
    assign link[0] = '{valid: 1'b1, greater: 1'b1, id: '0, score: '0};

    for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
        tnsr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cand    (cand),
            .clear   (s_first_item),
            .ins_en  (accept && !drop),
            .lim_ok  (CW'(j) < lim),
            .left_i  (link[j]),
            .link_o  (link[j+1])
        );
        assign entries[j] = '{id: link[j+1].id, score: link[j+1].score};
    end

    // Drop the candidate when the last slot inside the limit still outranks it
    always_comb begin
        drop = 1'b0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (CW'(j + 1) == lim) begin
                drop = link[j+1].greater;
            end
        end
    end

    // Entry count: clear on a query start, grow by one up to the limit
    assign count_base  = s_first_item ? '0 : count_reg;
    assign count_ins   = (count_base >= lim) ? lim : count_base + CW'(1);
    assign count_after = drop ? count_reg : count_ins;
    assign count_next  = accept ? count_after : count_reg;

    // Index of the final emitted entry: at most RESULT_LIMIT entries go out
    assign count_wide = EW'(count_after);
    always_comb begin
        if (count_wide > EW'(RESULT_LIMIT)) begin
            last_idx = RANK_W'(RESULT_LIMIT - 1);
        end else begin
            last_idx = RANK_W'(count_wide - EW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_n_reg <= TOP_N_RESET;
            count_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                top_n_reg <= cfg_data;
            end
            count_reg <= count_next;
        end
    end

    tnsr_emit #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (accept && s_last_item),
        .last_idx       (last_idx),
        .entries        (entries),
        .busy           (busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rank         (m_rank),
        .m_ranked_id    (m_ranked_id),
        .m_ranked_score (m_ranked_score),
        .m_final_entry  (m_final_entry)
    );

endmodule

`default_nettype wire

>>> rtl/core/tnsr_cell.sv
// ----------------------------------------------------------------------------
// tnsr_cell
// One list slot: compares against the candidate, then keeps, takes or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module tnsr_cell
    import tnsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tnsr_cand_t cand,
    input  wire logic       clear,    // query start: treat slot as empty
    input  wire logic       ins_en,   // candidate lands in the list this cycle
    input  wire logic       lim_ok,   // slot lies inside the list limit
    input  wire tnsr_link_t left_i,
    output tnsr_link_t      link_o
);

    logic                      valid_reg, valid_next;
    logic [ID_W-1:0]           id_reg, id_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic                      valid_eff;
    logic                      greater;

    assign valid_eff = valid_reg & ~clear;
    assign greater   = valid_eff && (score_reg > cand.score);

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        score_next = score_reg;
        if (ins_en) begin
            valid_next = left_i.valid && lim_ok;
            priority if (greater) begin
                // hold: entry stays ahead of the candidate
            end else if (left_i.greater) begin
                id_next    = cand.id;
                score_next = cand.score;
            end else begin
                id_next    = left_i.id;
                score_next = left_i.score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign link_o = '{valid: valid_eff, greater: greater, id: id_reg, score: score_reg};

endmodule

`default_nettype wire

>>> rtl/core/tnsr_emit.sv
// ----------------------------------------------------------------------------
// tnsr_emit
// Streams the list out in rank order through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tnsr_emit
    import tnsr_pkg::*;
#(
    parameter int MAX_ENTRIES = TNSR_MAX_ENTRIES
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [RANK_W-1:0]         last_idx,
    input  wire tnsr_entry_t               entries [MAX_ENTRIES],
    output logic                           busy,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [RANK_W-1:0]              m_rank,
    output logic [ID_W-1:0]                m_ranked_id,
    output logic signed [SCORE_W-1:0]      m_ranked_score,
    output logic                           m_final_entry
);

    localparam int EMIT_CELLS = (MAX_ENTRIES < RESULT_LIMIT) ? MAX_ENTRIES : RESULT_LIMIT;

    tnsr_state_t          state_reg, state_next;
    logic [RANK_W-1:0]    idx_reg, idx_next;
    logic [RANK_W-1:0]    last_reg, last_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 load;
    logic                 at_last;
    tnsr_entry_t          sel;

    assign at_last = (idx_reg == last_reg);

    // select the entry at the current rank
    always_comb begin
        sel = '0;
        for (int j = 0; j < EMIT_CELLS; j++) begin
            if (idx_reg == RANK_W'(j)) begin
                sel = entries[j];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_EMIT: begin
                busy = 1'b1;
                load = !m_valid_reg || m_ready;
            end
            default: busy = 1'b0;
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        if (start) begin
            idx_next  = '0;
            last_next = last_idx;
        end else if (load) begin
            idx_next = idx_reg + RANK_W'(1);
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_rank         <= idx_reg;
            m_ranked_id    <= sel.id;
            m_ranked_score <= sel.score;
            m_final_entry  <= at_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/tnsr_checker.sv
// ----------------------------------------------------------------------------
// tnsr_checker
// Port-level checks on the ranker: reset, output hold and list streaming.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_n_score_ranker_assert.svh"

module tnsr_checker
    import tnsr_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [RANK_W-1:0]         m_rank,
    input wire logic [ID_W-1:0]           m_ranked_id,
    input wire logic                      m_final_entry
);

    `TNSR_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `TNSR_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_ranked_id), "stalled item changed")

    `TNSR_ASSERT_RST(a_no_input_midlist, aclk, aresetn, m_valid && !m_final_entry |-> !s_ready, "input taken while list streams")

    `TNSR_ASSERT_RST(a_rank_step, aclk, aresetn, m_valid && m_ready && !m_final_entry |=> m_valid && (m_rank == $past(m_rank) + RANK_W'(1)), "rank sequence broken")

endmodule

bind top_n_score_ranker tnsr_checker u_tnsr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_rank        (m_rank),
    .m_ranked_id   (m_ranked_id),
    .m_final_entry (m_final_entry)
);

`default_nettype wire
